### rtl/pbt_pkg.sv
// ----------------------------------------------------------------------------
// pbt_pkg
// Shared widths, request codes, register indexes and the result record of the
// pivot basis tracker.
// ----------------------------------------------------------------------------
package pbt_pkg;

    localparam int REQ_W        = 3;
    localparam int ROW_W        = 5;
    localparam int LABEL_W      = 7;
    localparam int ROWS_CFG_W   = 5;
    localparam int COLS_CFG_W   = 6;
    localparam int ADDR_W       = 3;
    localparam int DATA_W       = 32;
    // wide enough for any label magnitude, row number or column count
    localparam int NUM_W        = 8;

    localparam int MAX_ROWS_DEF = 16;
    localparam int MAX_COLS_DEF = 32;

    localparam logic [ROWS_CFG_W-1:0] ROWS_RESET = ROWS_CFG_W'(16);
    localparam logic [COLS_CFG_W-1:0] COLS_RESET = COLS_CFG_W'(32);

    typedef enum logic [REQ_W-1:0] {
        REQ_PIVOT   = 3'd0,
        REQ_QUERY   = 3'd1,
        REQ_MARK    = 3'd2,
        REQ_UNMARK  = 3'd3,
        REQ_RESTART = 3'd4
    } req_t;

    typedef enum logic {
        CFG_ROWS = 1'b0,
        CFG_COLS = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic signed [LABEL_W-1:0] leaving_label;
        logic [ROW_W-1:0]          row_of_label;
        logic                      in_basis;
        logic                      label_blocked;
        logic signed [LABEL_W-1:0] label_at_row;
        logic                      basis_is_identity;
        logic                      bad_column;
        logic                      bad_row;
    } res_t;

endpackage

### rtl/pivot_basis_tracker.sv
// ----------------------------------------------------------------------------
// pivot_basis_tracker
// Basis bookkeeping for a pivoting linear solver: row labels, reverse maps,
// blocked marks and an identity flag kept by a mismatch counter.
// ----------------------------------------------------------------------------
// Usage:
//   request channel (req_valid / req_stall) carries req_type, row_index and
//   column_label; one response per request leaves on rsp_valid / rsp_stall.
//   All tables sit in flops; each request is decoded, applied and its
//   response formed in the cycle it is accepted and written to the response
//   buffer. One request per cycle is sustained while req_stall is low.
//   A two-entry response buffer lets a request be taken while an earlier
//   response waits; req_stall rises only when both entries are full.
//   rows_in_use and cols_in_use are written through the APB port; the user
//   must do so only while the block is idle, which the block does not check;
//   change rows_in_use only before a restart request. Reset loads the
//   identity basis (row r holds slack r), clears all regular maps and blocked
//   marks, sets rows_in_use 16 and cols_in_use 32 and empties the response
//   buffer. A stalled response holds its value until the receiver takes it.
// ----------------------------------------------------------------------------
module pivot_basis_tracker #(
    parameter int MAX_ROWS = pbt_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = pbt_pkg::MAX_COLS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [pbt_pkg::ADDR_W-1:0]         paddr,
    input  logic [pbt_pkg::DATA_W-1:0]         pwdata,
    output logic [pbt_pkg::DATA_W-1:0]         prdata,
    output logic                               pready,

    input  logic                               req_valid,
    output logic                               req_stall,
    input  logic [pbt_pkg::REQ_W-1:0]          req_type,
    input  logic [pbt_pkg::ROW_W-1:0]          row_index,
    input  logic signed [pbt_pkg::LABEL_W-1:0] column_label,

    output logic                               rsp_valid,
    input  logic                               rsp_stall,
    output logic signed [pbt_pkg::LABEL_W-1:0] leaving_label,
    output logic [pbt_pkg::ROW_W-1:0]          row_of_label,
    output logic                               in_basis,
    output logic                               label_blocked,
    output logic signed [pbt_pkg::LABEL_W-1:0] label_at_row,
    output logic                               basis_is_identity,
    output logic                               bad_column,
    output logic                               bad_row
);
    import pbt_pkg::*;

    localparam int CNT_W = $clog2(MAX_ROWS + 1);

    // configuration
    logic [ROWS_CFG_W-1:0] rows_in_use_reg;
    logic [COLS_CFG_W-1:0] cols_in_use_reg;
    logic                  cfg_write;

    // basis state
    logic signed [LABEL_W-1:0] row_label_reg [MAX_ROWS];
    logic [ROW_W-1:0]          slack_row_reg [MAX_ROWS];
    logic [ROW_W-1:0]          regular_row_reg [MAX_COLS];
    logic                      slack_blocked_reg [MAX_ROWS];
    logic                      regular_blocked_reg [MAX_COLS];
    logic [CNT_W-1:0]          mismatch_reg;

    logic signed [LABEL_W-1:0] row_label_next [MAX_ROWS];
    logic [ROW_W-1:0]          slack_row_next [MAX_ROWS];
    logic [ROW_W-1:0]          regular_row_next [MAX_COLS];
    logic                      slack_blocked_next [MAX_ROWS];
    logic                      regular_blocked_next [MAX_COLS];
    logic [CNT_W-1:0]          mismatch_next;

    // request decode
    logic [NUM_W-1:0]          eff_rows;
    logic [NUM_W-1:0]          eff_cols;
    logic [NUM_W-1:0]          c_pos;
    logic [NUM_W-1:0]          c_neg;
    logic                      c_slack;
    logic                      c_regular;
    logic                      c_valid;
    logic [NUM_W-1:0]          r_num;
    logic [NUM_W-1:0]          minus_r;
    logic                      r_ok;
    logic signed [LABEL_W-1:0] old_label;
    logic [NUM_W-1:0]          old_pos;
    logic [NUM_W-1:0]          old_neg;
    logic                      old_slack;
    logic                      old_regular;
    logic [ROW_W-1:0]          cur_map_c;
    logic                      is_pivot;
    logic                      is_query;
    logic                      pivot_go;
    res_t                      res;

    // response buffer
    res_t                      fifo_reg [2];
    logic                      wr_ptr_reg;
    logic                      rd_ptr_reg;
    logic [1:0]                fill_reg;
    logic                      req_fire;
    logic                      rsp_fire;
    res_t                      head;

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        case (cfg_idx_t'(paddr[2]))
            CFG_ROWS: prdata = DATA_W'(rows_in_use_reg);
            CFG_COLS: prdata = DATA_W'(cols_in_use_reg);
            default:  prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_in_use_reg <= ROWS_RESET;
            cols_in_use_reg <= COLS_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_idx_t'(paddr[2]))
                CFG_ROWS: rows_in_use_reg <= pwdata[ROWS_CFG_W-1:0];
                CFG_COLS: cols_in_use_reg <= pwdata[COLS_CFG_W-1:0];
                default:  ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // request decode
    // ------------------------------------------------------------------
    always_comb
    begin
        eff_rows = (NUM_W'(rows_in_use_reg) > NUM_W'(MAX_ROWS)) ?
                   NUM_W'(MAX_ROWS) : NUM_W'(rows_in_use_reg);
        eff_cols = (NUM_W'(cols_in_use_reg) > NUM_W'(MAX_COLS)) ?
                   NUM_W'(MAX_COLS) : NUM_W'(cols_in_use_reg);

        c_pos     = {{(NUM_W-LABEL_W){column_label[LABEL_W-1]}}, column_label};
        c_neg     = -c_pos;
        c_slack   = column_label[LABEL_W-1] && (c_neg <= eff_rows);
        c_regular = !column_label[LABEL_W-1] && (c_pos != '0) && (c_pos <= eff_cols);
        c_valid   = c_slack || c_regular;

        r_num   = NUM_W'(row_index);
        minus_r = -r_num;
        r_ok    = (r_num != '0) && (r_num <= eff_rows);

        old_label = '0;
        for (int i = 0; i < MAX_ROWS; i++)
        begin
            if (r_num == NUM_W'(i + 1))
                old_label = row_label_reg[i];
        end
        old_pos     = {{(NUM_W-LABEL_W){old_label[LABEL_W-1]}}, old_label};
        old_neg     = -old_pos;
        old_slack   = old_label[LABEL_W-1] && (old_neg <= eff_rows);
        old_regular = !old_label[LABEL_W-1] && (old_pos != '0) && (old_pos <= eff_cols);

        cur_map_c = '0;
        for (int i = 0; i < MAX_ROWS; i++)
        begin
            if (c_slack && c_neg == NUM_W'(i + 1))
                cur_map_c = slack_row_reg[i];
        end
        for (int i = 0; i < MAX_COLS; i++)
        begin
            if (c_regular && c_pos == NUM_W'(i + 1))
                cur_map_c = regular_row_reg[i];
        end

        is_pivot = (req_t'(req_type) == REQ_PIVOT);
        is_query = (req_t'(req_type) == REQ_QUERY);
        // a row whose stored label is out of range under the current
        // registers makes the pivot a silent no-op
        pivot_go = is_pivot && r_ok && c_valid && (cur_map_c == '0) &&
                   (old_slack || old_regular);
    end

    // ------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------
    always_comb
    begin
        for (int i = 0; i < MAX_ROWS; i++)
        begin
            row_label_next[i]     = row_label_reg[i];
            slack_row_next[i]     = slack_row_reg[i];
            slack_blocked_next[i] = slack_blocked_reg[i];
        end
        for (int i = 0; i < MAX_COLS; i++)
        begin
            regular_row_next[i]     = regular_row_reg[i];
            regular_blocked_next[i] = regular_blocked_reg[i];
        end
        mismatch_next = mismatch_reg;

        case (req_t'(req_type))
            REQ_PIVOT:
            begin
                if (pivot_go)
                begin
                    // leaving label's map cleared first, entering label wins
                    for (int i = 0; i < MAX_ROWS; i++)
                    begin
                        if (old_slack && old_neg == NUM_W'(i + 1))
                            slack_row_next[i] = '0;
                        if (c_slack && c_neg == NUM_W'(i + 1))
                            slack_row_next[i] = row_index;
                        if (r_num == NUM_W'(i + 1))
                            row_label_next[i] = column_label;
                    end
                    for (int i = 0; i < MAX_COLS; i++)
                    begin
                        if (old_regular && old_pos == NUM_W'(i + 1))
                            regular_row_next[i] = '0;
                        if (c_regular && c_pos == NUM_W'(i + 1))
                            regular_row_next[i] = row_index;
                    end
                    mismatch_next = mismatch_reg
                                  - CNT_W'(old_pos != minus_r)
                                  + CNT_W'(c_pos != minus_r);
                end
            end
            REQ_MARK, REQ_UNMARK:
            begin
                for (int i = 0; i < MAX_ROWS; i++)
                begin
                    if (c_slack && c_neg == NUM_W'(i + 1))
                        slack_blocked_next[i] = (req_t'(req_type) == REQ_MARK);
                end
                for (int i = 0; i < MAX_COLS; i++)
                begin
                    if (c_regular && c_pos == NUM_W'(i + 1))
                        regular_blocked_next[i] = (req_t'(req_type) == REQ_MARK);
                end
            end
            REQ_RESTART:
            begin
                for (int i = 0; i < MAX_ROWS; i++)
                begin
                    row_label_next[i]     = LABEL_W'(-(i + 1));
                    slack_row_next[i]     = ROW_W'(i + 1);
                    slack_blocked_next[i] = 1'b0;
                end
                for (int i = 0; i < MAX_COLS; i++)
                begin
                    regular_row_next[i]     = '0;
                    regular_blocked_next[i] = 1'b0;
                end
                mismatch_next = '0;
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // response, read from the updated state
    // ------------------------------------------------------------------
    always_comb
    begin
        res = '0;
        res.leaving_label = pivot_go ? old_label : '0;

        for (int i = 0; i < MAX_ROWS; i++)
        begin
            if (c_slack && c_neg == NUM_W'(i + 1))
            begin
                res.row_of_label  = slack_row_next[i];
                res.label_blocked = slack_blocked_next[i];
            end
            if (r_ok && r_num == NUM_W'(i + 1))
                res.label_at_row = row_label_next[i];
        end
        for (int i = 0; i < MAX_COLS; i++)
        begin
            if (c_regular && c_pos == NUM_W'(i + 1))
            begin
                res.row_of_label  = regular_row_next[i];
                res.label_blocked = regular_blocked_next[i];
            end
        end
        res.in_basis          = (res.row_of_label != '0);
        res.basis_is_identity = (mismatch_next == '0);
        res.bad_column        = (is_pivot && (!c_valid || cur_map_c != '0)) ||
                                (is_query && !c_valid);
        res.bad_row           = (is_pivot || is_query) && !r_ok;
    end

    // ------------------------------------------------------------------
    // state registers
    // ------------------------------------------------------------------
    assign req_fire = req_valid && !req_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_ROWS; i++)
            begin
                row_label_reg[i]     <= LABEL_W'(-(i + 1));
                slack_row_reg[i]     <= ROW_W'(i + 1);
                slack_blocked_reg[i] <= 1'b0;
            end
            for (int i = 0; i < MAX_COLS; i++)
            begin
                regular_row_reg[i]     <= '0;
                regular_blocked_reg[i] <= 1'b0;
            end
            mismatch_reg <= '0;
        end
        else if (req_fire)
        begin
            for (int i = 0; i < MAX_ROWS; i++)
            begin
                row_label_reg[i]     <= row_label_next[i];
                slack_row_reg[i]     <= slack_row_next[i];
                slack_blocked_reg[i] <= slack_blocked_next[i];
            end
            for (int i = 0; i < MAX_COLS; i++)
            begin
                regular_row_reg[i]     <= regular_row_next[i];
                regular_blocked_reg[i] <= regular_blocked_next[i];
            end
            mismatch_reg <= mismatch_next;
        end
    end

    // ------------------------------------------------------------------
    // two-entry response buffer
    // ------------------------------------------------------------------
    assign rsp_valid = (fill_reg != 2'd0);
    assign req_stall = (fill_reg == 2'd2);
    assign rsp_fire  = rsp_valid && !rsp_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (req_fire)
                wr_ptr_reg <= !wr_ptr_reg;
            if (rsp_fire)
                rd_ptr_reg <= !rd_ptr_reg;
            if (req_fire && !rsp_fire)
                fill_reg <= fill_reg + 2'd1;
            else if (rsp_fire && !req_fire)
                fill_reg <= fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
            fifo_reg[wr_ptr_reg] <= res;
    end

    assign head              = fifo_reg[rd_ptr_reg];
    assign leaving_label     = head.leaving_label;
    assign row_of_label      = head.row_of_label;
    assign in_basis          = head.in_basis;
    assign label_blocked     = head.label_blocked;
    assign label_at_row      = head.label_at_row;
    assign basis_is_identity = head.basis_is_identity;
    assign bad_column        = head.bad_column;
    assign bad_row           = head.bad_row;

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for pivot_basis_tracker. A short table of requests runs
// first, then random pivots, queries, marks and restarts under several row and
// column settings. Responses are checked against table values or a cycle-free
// basis model kept here, with bursty requests and a stalling response side.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pbt_pkg::*;

    localparam int IDLE_LIMIT      = 2000;
    localparam int HOLD_CYCLES     = 80;
    localparam int N_PHASES        = 8;
    localparam int ITEMS_PER_PHASE = 228;

    localparam logic [REQ_W-1:0] REQ_SPARE_LO = 3'd5;
    localparam logic [REQ_W-1:0] REQ_SPARE_HI = 3'd7;

    localparam int PH_ROWS [N_PHASES]    = '{16, 1, 31, 16, 4, 0, 8, 16};
    localparam int PH_COLS [N_PHASES]    = '{32, 1, 63, 16, 32, 0, 20, 32};
    localparam bit PH_RESTART [N_PHASES] = '{0, 1, 1, 0, 0, 1, 1, 1};

    typedef struct {
        logic [REQ_W-1:0]          kind;
        logic [ROW_W-1:0]          row;
        logic signed [LABEL_W-1:0] lab;
        bit                        typed;
        res_t                      want;
    } drill_t;

    // want = leaving, row_of, in_basis, blocked, at_row, identity, bad_col, bad_row
    drill_t drill [25] = '{
        '{REQ_QUERY,     1,  -1, 1'b1, '{0, 1, 1, 0, -1, 1, 0, 0}},
        '{REQ_QUERY,     0,   0, 1'b1, '{0, 0, 0, 0, 0, 1, 1, 1}},
        '{REQ_QUERY,    31, -64, 1'b1, '{0, 0, 0, 0, 0, 1, 1, 1}},
        '{REQ_QUERY,    16,  63, 1'b1, '{0, 0, 0, 0, -16, 1, 1, 0}},
        '{REQ_QUERY,    17, -16, 1'b1, '{0, 16, 1, 0, 0, 1, 0, 1}},
        '{REQ_PIVOT,     0,   7, 1'b1, '{0, 0, 0, 0, 0, 1, 0, 1}},
        '{REQ_PIVOT,     2,  -2, 1'b1, '{0, 2, 1, 0, -2, 1, 1, 0}},
        '{REQ_PIVOT,     3,   5, 1'b0, '0},
        '{REQ_PIVOT,    16,  32, 1'b0, '0},
        '{REQ_PIVOT,     4,   5, 1'b0, '0},
        '{REQ_PIVOT,     5, -64, 1'b0, '0},
        '{REQ_PIVOT,     6,  -3, 1'b0, '0},
        '{REQ_MARK,      1,   5, 1'b0, '0},
        '{REQ_MARK,      1, -64, 1'b0, '0},
        '{REQ_MARK,      7, -16, 1'b0, '0},
        '{REQ_MARK,      2,  63, 1'b0, '0},
        '{REQ_QUERY,     3,   5, 1'b0, '0},
        '{REQ_UNMARK,    3,   5, 1'b0, '0},
        '{REQ_UNMARK,    0, -64, 1'b0, '0},
        '{REQ_QUERY,    16, -16, 1'b0, '0},
        '{REQ_SPARE_LO,  2,   1, 1'b0, '0},
        '{REQ_SPARE_HI, 31,  -1, 1'b0, '0},
        '{REQ_PIVOT,     3,  -6, 1'b0, '0},
        '{REQ_RESTART,   1,   1, 1'b1, '{0, 0, 0, 0, -1, 1, 0, 0}},
        '{REQ_QUERY,     2, -16, 1'b1, '{0, 16, 1, 0, -2, 1, 0, 0}}
    };

    logic                        clk = 1'b0;
    logic                        rst_n;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [ADDR_W-1:0]           paddr;
    logic [DATA_W-1:0]           pwdata;
    logic [DATA_W-1:0]           prdata;
    logic                        pready;
    logic                        req_valid;
    logic                        req_stall;
    logic [REQ_W-1:0]            req_type;
    logic [ROW_W-1:0]            row_index;
    logic signed [LABEL_W-1:0]   column_label;
    logic                        rsp_valid;
    logic                        rsp_stall;
    logic signed [LABEL_W-1:0]   leaving_label;
    logic [ROW_W-1:0]            row_of_label;
    logic                        in_basis;
    logic                        label_blocked;
    logic signed [LABEL_W-1:0]   label_at_row;
    logic                        basis_is_identity;
    logic                        bad_column;
    logic                        bad_row;

    // basis model
    logic [ROWS_CFG_W-1:0]       rows_reg;
    logic [COLS_CFG_W-1:0]       cols_reg;
    logic signed [LABEL_W-1:0]   row_lab   [0:MAX_ROWS_DEF];
    logic [ROW_W-1:0]            slack_pos [0:MAX_ROWS_DEF];
    logic [ROW_W-1:0]            reg_pos   [0:MAX_COLS_DEF];
    bit                          slack_blk [0:MAX_ROWS_DEF];
    bit                          reg_blk   [0:MAX_COLS_DEF];
    int                          off_diag;

    res_t pending_rsp [$];
    int   err_cnt    = 0;
    int   burst_left = 0;
    int   quiet      = 0;
    bit   hold_req   = 1'b0;

    pivot_basis_tracker DUT (.*);

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int rows_live();
        return (rows_reg > MAX_ROWS_DEF) ? MAX_ROWS_DEF : int'(rows_reg);
    endfunction

    function automatic int cols_live();
        return (cols_reg > MAX_COLS_DEF) ? MAX_COLS_DEF : int'(cols_reg);
    endfunction

    function automatic bit is_slack_lab(input int c);
        return c < 0 && -c <= rows_live();
    endfunction

    function automatic bit is_reg_lab(input int c);
        return c > 0 && c <= cols_live();
    endfunction

    function automatic int lab_row(input int c);
        if (is_slack_lab(c))
            return slack_pos[-c];
        if (is_reg_lab(c))
            return reg_pos[c];
        return 0;
    endfunction

    function automatic void set_lab_row(input int c, input int r);
        if (is_slack_lab(c))
            slack_pos[-c] = ROW_W'(r);
        else if (is_reg_lab(c))
            reg_pos[c] = ROW_W'(r);
    endfunction

    function automatic bit lab_blk(input int c);
        if (is_slack_lab(c))
            return slack_blk[-c];
        if (is_reg_lab(c))
            return reg_blk[c];
        return 1'b0;
    endfunction

    function automatic void set_lab_blk(input int c, input bit v);
        if (is_slack_lab(c))
            slack_blk[-c] = v;
        else if (is_reg_lab(c))
            reg_blk[c] = v;
    endfunction

    function automatic void clear_basis();
        for (int i = 0; i <= MAX_ROWS_DEF; i++)
        begin
            row_lab[i]   = LABEL_W'(-i);
            slack_pos[i] = ROW_W'(i);
            slack_blk[i] = 1'b0;
        end
        for (int i = 0; i <= MAX_COLS_DEF; i++)
        begin
            reg_pos[i] = '0;
            reg_blk[i] = 1'b0;
        end
        off_diag = 0;
    endfunction

    function automatic res_t step_basis(input logic [REQ_W-1:0] kind,
                                        input logic [ROW_W-1:0] row,
                                        input logic signed [LABEL_W-1:0] lab);
        int   c;
        int   r;
        int   old;
        int   pos;
        bit   lab_ok;
        bit   row_ok;
        res_t res;
        c      = lab;
        r      = row;
        lab_ok = is_slack_lab(c) || is_reg_lab(c);
        row_ok = r >= 1 && r <= rows_live();
        res    = '0;
        case (kind)
            REQ_PIVOT:
            begin
                res.bad_row    = !row_ok;
                res.bad_column = !lab_ok || lab_row(c) != 0;
                if (row_ok && !res.bad_column)
                begin
                    old = row_lab[r];
                    // a row left holding an out-of-range label cannot pivot
                    if (is_slack_lab(old) || is_reg_lab(old))
                    begin
                        set_lab_row(old, 0);
                        set_lab_row(c, r);
                        if (old != -r)
                            off_diag--;
                        if (c != -r)
                            off_diag++;
                        row_lab[r]        = LABEL_W'(c);
                        res.leaving_label = LABEL_W'(old);
                    end
                end
            end
            REQ_QUERY:
            begin
                res.bad_row    = !row_ok;
                res.bad_column = !lab_ok;
            end
            REQ_MARK:    set_lab_blk(c, 1'b1);
            REQ_UNMARK:  set_lab_blk(c, 1'b0);
            REQ_RESTART: clear_basis();
            default: ;
        endcase
        pos                   = lab_row(c);
        res.row_of_label      = ROW_W'(pos);
        res.in_basis          = pos != 0;
        res.label_blocked     = lab_blk(c);
        res.label_at_row      = row_ok ? row_lab[r] : '0;
        res.basis_is_identity = off_diag == 0;
        return res;
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_cnt++;
        end
    endfunction

    function automatic logic signed [LABEL_W-1:0] any_label();
        int nr;
        int nc;
        nr = rows_live();
        nc = cols_live();
        if (nr + nc == 0)
            return LABEL_W'($urandom);
        if ($urandom_range(1, nr + nc) <= nr)
            return LABEL_W'(-int'($urandom_range(1, nr)));
        return LABEL_W'($urandom_range(1, nc));
    endfunction

    function automatic logic signed [LABEL_W-1:0] free_label();
        logic signed [LABEL_W-1:0] lab;
        int                        t;
        lab = any_label();
        for (t = 0; t < 8 && lab_row(lab) != 0; t++)
            lab = any_label();
        return lab;
    endfunction

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic offer(input logic [REQ_W-1:0] kind, input logic [ROW_W-1:0] row,
                         input logic signed [LABEL_W-1:0] lab, input bit typed,
                         input res_t want);
        int   gap;
        res_t guess;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            burst_left = $urandom_range(1, 24);
            if (gap > 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        req_valid    <= 1'b1;
        req_type     <= kind;
        row_index    <= row;
        column_label <= lab;
        do
            @(posedge clk);
        while (req_stall);
        guess = step_basis(kind, row, lab);
        pending_rsp.push_back(typed ? want : guess);
        @(negedge clk);
    endtask

    // sender waits out every response before the registers move
    task automatic drain();
        req_valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic apb_access(input bit wr, input cfg_idx_t idx,
                              input logic [DATA_W-1:0] data,
                              output logic [DATA_W-1:0] rd);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rd = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input int value);
        logic [DATA_W-1:0] rd;
        apb_access(1'b1, idx, DATA_W'(value), rd);
        if (idx == CFG_ROWS)
            rows_reg = ROWS_CFG_W'(value);
        else
            cols_reg = COLS_CFG_W'(value);
        apb_access(1'b0, idx, '0, rd);
        check_field(idx == CFG_ROWS ? "rows_in_use" : "cols_in_use", value, int'(rd));
    endtask

    task automatic random_item();
        logic [REQ_W-1:0]          kind;
        logic [ROW_W-1:0]          row;
        logic signed [LABEL_W-1:0] lab;
        int                        pick;
        int                        nr;
        nr   = rows_live();
        pick = $urandom_range(0, 99);
        if (pick < 46)
            kind = REQ_PIVOT;
        else if (pick < 70)
            kind = REQ_QUERY;
        else if (pick < 82)
            kind = REQ_MARK;
        else if (pick < 94)
            kind = REQ_UNMARK;
        else if (pick < 97)
            kind = REQ_RESTART;
        else
            kind = REQ_W'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI));
        if (nr > 0 && $urandom_range(0, 9) != 0)
            row = ROW_W'($urandom_range(1, nr));
        else
            row = ROW_W'($urandom);
        pick = $urandom_range(0, 9);
        if (pick >= 8)
            lab = LABEL_W'($urandom);
        else if (kind == REQ_PIVOT)
            lab = free_label();
        else
            lab = any_label();
        // sending a slack back to its own row walks toward the identity basis
        if (kind == REQ_PIVOT && lab < 0 && -int'(lab) <= nr && $urandom_range(0, 2) == 0)
            row = ROW_W'(-int'(lab));
        offer(kind, row, lab, 1'b0, '0);
    endtask

    always @(posedge clk)
    begin : rsp_check
        res_t seen;
        res_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            seen = '{leaving_label, row_of_label, in_basis, label_blocked, label_at_row,
                     basis_is_identity, bad_column, bad_row};
            if (pending_rsp.size() == 0)
            begin
                $error("response transfer with nothing outstanding");
                err_cnt++;
            end
            else
            begin
                want = pending_rsp.pop_front();
                check_field("leaving_label", $signed(want.leaving_label),
                            $signed(seen.leaving_label));
                check_field("row_of_label", want.row_of_label, seen.row_of_label);
                check_field("in_basis", want.in_basis, seen.in_basis);
                check_field("label_blocked", want.label_blocked, seen.label_blocked);
                check_field("label_at_row", $signed(want.label_at_row),
                            $signed(seen.label_at_row));
                check_field("basis_is_identity", want.basis_is_identity,
                            seen.basis_is_identity);
                check_field("bad_column", want.bad_column, seen.bad_column);
                check_field("bad_row", want.bad_row, seen.bad_row);
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || psel)
            quiet = 0;
        else
        begin
            quiet++;
            if (quiet >= IDLE_LIMIT)
            begin
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    initial
    begin : rsp_side
        int mode;
        int left;
        int hold_cnt;
        int cyc;
        mode      = 0;
        left      = 0;
        hold_cnt  = 0;
        cyc       = 0;
        rsp_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_cnt = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (left == 0)
            begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(50, 300);
            end
            left--;
            cyc++;
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                rsp_stall <= 1'b1;
            end
            else
            begin
                case (mode)
                    0:       rsp_stall <= 1'b0;
                    1:       rsp_stall <= ($urandom_range(0, 3) == 0);
                    2:       rsp_stall <= ($urandom_range(0, 3) != 0);
                    default: rsp_stall <= ((cyc % 7) < 3);
                endcase
            end
        end
    end

    initial
    begin : stimulus
        int ph;
        int n;
        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        req_valid    = 1'b0;
        req_type     = REQ_QUERY;
        row_index    = '0;
        column_label = '0;
        rows_reg     = ROWS_RESET;
        cols_reg     = COLS_RESET;
        clear_basis();
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (drill[i])
            offer(drill[i].kind, drill[i].row, drill[i].lab, drill[i].typed, drill[i].want);

        // some settings shrink rows or columns without a restart on purpose
        for (ph = 0; ph < N_PHASES; ph++)
        begin
            drain();
            write_reg(CFG_ROWS, PH_ROWS[ph]);
            write_reg(CFG_COLS, PH_COLS[ph]);
            if (PH_RESTART[ph])
                offer(REQ_RESTART, '0, '0, 1'b0, '0);
            if (ph == 0 || ph == 6)
                hold_req = 1'b1;
            for (n = 0; n < ITEMS_PER_PHASE; n++)
                random_item();
        end

        drain();
        repeat (4) @(posedge clk);
        if (err_cnt == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
